### rtl/fbd_pkg.sv
// fbd_pkg: shared constants, action codes and color conversion for the draw engine
// used by the palette and the top module of the packed 4bpp framebuffer draw engine
package fbd_pkg;

  localparam int DefFrameWidth  = 640;
  localparam int DefFrameHeight = 480;
  localparam int DefRowBytes    = 320;

  // byte columns of a row never exceed 1024 (2048 visible pixels)
  localparam int ColW = 10;

  localparam logic [2:0] ActPlot  = 3'd0;
  localparam logic [2:0] ActRun   = 3'd1;
  localparam logic [2:0] ActGlyph = 3'd2;
  localparam logic [2:0] ActClear = 3'd3;
  localparam logic [2:0] ActPal   = 3'd4;
  localparam logic [2:0] ActRead  = 3'd5;

  localparam logic [23:0] DefaultRgb [16] = '{
    24'h000000, 24'h000080, 24'h008000, 24'h008080,
    24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
    24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  function automatic logic [15:0] to_565(input logic [23:0] c);
    to_565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

### rtl/fbd_ram.sv
// fbd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module fbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fbd_palette.sv
// fbd_palette: 16-entry rgb565 palette, loaded with default colors at reset
// depends on fbd_pkg for the default table and the rgb888 to rgb565 conversion
module fbd_palette import fbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [3:0]  widx_i,
  input  logic [23:0] wrgb_i,
  input  logic [3:0]  ridx_i,
  output logic [15:0] rdata_o
);

  logic [15:0] pal_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        pal_q[i] <= to_565(DefaultRgb[i]);
      end
    end else if (we_i) begin
      pal_q[widx_i] <= to_565(wrgb_i);
    end
  end

  assign rdata_o = pal_q[ridx_i];

endmodule

### rtl/packed_4bpp_framebuffer_draw_engine.sv
// packed_4bpp_framebuffer_draw_engine: command sequencer over the packed frame store
// depends on fbd_pkg, fbd_ram and fbd_palette
//
// usage: one request enters on the input channel (in_valid_i / in_stall_o) and
// exactly one result leaves on the output channel (out_valid_o / out_stall_i).
// one request is worked at a time; in_stall_o is high while it is in flight.
// how each request uses the single read/write port pair of the frame store:
//   palette write, out-of-frame plot or read, unused action: no frame store access
//   plot and read: one byte read, then modify/write or palette lookup
//   glyph row: up to four byte writes, one per pixel pair inside the frame
//   run fill: one write per full byte, a read and then a write per partial end byte
//   clear: every byte of the frame store, one byte written per cycle
// after reset every byte of the frame store is swept to zero, with in_stall_o high;
// the palette returns to its sixteen default colors at once.
// the result sits in an output register; a stalled receiver holds it there and
// the block takes the next request meanwhile, but finishes that one only once
// the output register is free.
module packed_4bpp_framebuffer_draw_engine import fbd_pkg::*; #(
  parameter int FRAME_WIDTH  = DefFrameWidth,
  parameter int FRAME_HEIGHT = DefFrameHeight,
  parameter int ROW_BYTES    = DefRowBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  input  logic signed [11:0] run_length_i,
  input  logic [3:0]         fore_color_i,
  input  logic [3:0]         back_color_i,
  input  logic [7:0]         glyph_bits_i,
  input  logic [3:0]         palette_index_i,
  input  logic [23:0]        rgb_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         pixel_index_o,
  output logic [15:0]        pixel_rgb565_o,
  output logic               in_range_o
);

  localparam int StoreBytes = ROW_BYTES * FRAME_HEIGHT;
  localparam int AW = $clog2(StoreBytes);
  localparam int Vis = (FRAME_WIDTH < 2 * ROW_BYTES) ? FRAME_WIDTH : 2 * ROW_BYTES;
  localparam logic signed [13:0] VisS = 14'(Vis);
  localparam logic signed [13:0] HeightS = 14'(FRAME_HEIGHT);
  localparam logic [AW-1:0] LastAddr = AW'(StoreBytes - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_CLR   = 3'd7;

  logic [2:0] state_q, state_d;
  logic ovld_q, ovld_d;
  logic clr_cmd_q, clr_cmd_d;

  logic [2:0] act_q;
  logic signed [11:0] x_q, y_q, len_q;
  logic [3:0] fg_q, bg_q, pidx_q;
  logic [7:0] bits_q;
  logic [23:0] rgb_q;

  logic [AW-1:0] base_q, base_d;
  logic signed [13:0] s_q, s_d, e_q, e_d;
  logic [ColW-1:0] bc_q, bc_d, endc_q, endc_d;
  logic [1:0] k_q, k_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [1:0] mask_q, mask_d;
  logic last_q, last_d;
  logic [3:0] res_idx_q, res_idx_d;
  logic [15:0] res_rgb_q, res_rgb_d;
  logic res_in_q, res_in_d;
  logic [3:0] out_idx_q, out_idx_d;
  logic [15:0] out_rgb_q, out_rgb_d;
  logic out_in_q, out_in_d;

  logic accept;
  logic signed [13:0] x14, y14, len14, s_c, e_raw, e_c, bx, pix;
  logic row_ok, col_ok, hi_c, lo_c, gvalid;
  logic [1:0] sel;
  logic [3:0] rd_nib;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic pal_we;
  logic [15:0] pal_rd;

  fbd_ram #(.WIDTH(8), .DEPTH(StoreBytes)) u_frame (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  fbd_palette u_pal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (pal_we),
    .widx_i (pidx_q),
    .wrgb_i (rgb_q),
    .ridx_i (rd_nib),
    .rdata_o(pal_rd)
  );

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign x14 = {{2{x_q[11]}}, x_q};
  assign y14 = {{2{y_q[11]}}, y_q};
  assign len14 = {{2{len_q[11]}}, len_q};
  assign row_ok = (y14 >= 14'sd0) && (y14 < HeightS);
  assign col_ok = (x14 >= 14'sd0) && (x14 < VisS);
  assign s_c = (x14 < 14'sd0) ? 14'sd0 : x14;
  assign e_raw = x14 + len14;
  assign e_c = (e_raw > VisS) ? VisS : e_raw;
  assign bx = (x14 >>> 1) + $signed({12'd0, k_q});
  assign gvalid = (bx >= 14'sd0) && ((bx <<< 1) < VisS);
  assign sel = bits_q[{k_q, 1'b0} +: 2];
  assign pix = $signed({3'd0, bc_q, 1'b0});
  assign hi_c = (pix >= s_q);
  assign lo_c = (pix + 14'sd1 < e_q);
  assign rd_nib = x_q[0] ? rdata[3:0] : rdata[7:4];

  always_comb begin
    state_d = state_q;
    ovld_d = ovld_q && out_stall_i;
    clr_cmd_d = clr_cmd_q;
    base_d = base_q;
    s_d = s_q;
    e_d = e_q;
    bc_d = bc_q;
    endc_d = endc_q;
    k_d = k_q;
    addr_d = addr_q;
    mask_d = mask_q;
    last_d = last_q;
    res_idx_d = res_idx_q;
    res_rgb_d = res_rgb_q;
    res_in_d = res_in_q;
    out_idx_d = out_idx_q;
    out_rgb_d = out_rgb_q;
    out_in_d = out_in_q;
    we = 1'b0;
    re = 1'b0;
    waddr = addr_q;
    raddr = addr_q;
    wdata = 8'd0;
    pal_we = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        base_d = AW'(y_q[10:0]) * AW'(ROW_BYTES);
        res_idx_d = 4'd0;
        res_rgb_d = 16'd0;
        res_in_d = 1'b0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (act_q)
          ActPlot: begin
            if (row_ok && col_ok) begin
              re = 1'b1;
              raddr = base_q + AW'(x_q[10:1]);
              addr_d = raddr;
              mask_d = {!x_q[0], x_q[0]};
              last_d = 1'b1;
              res_in_d = 1'b1;
              state_d = S_RMW;
            end
          end
          ActRead: begin
            if (row_ok && col_ok) begin
              re = 1'b1;
              raddr = base_q + AW'(x_q[10:1]);
              state_d = S_RDW;
            end
          end
          ActRun: begin
            if (len_q > 12'sd0 && row_ok && s_c < e_c) begin
              s_d = s_c;
              e_d = e_c;
              bc_d = s_c[ColW:1];
              endc_d = 10'((e_c - 14'sd1) >>> 1);
              state_d = S_RUN;
            end
          end
          ActGlyph: begin
            if (row_ok) begin
              k_d = 2'd0;
              state_d = S_RUN;
            end
          end
          ActClear: begin
            addr_d = '0;
            clr_cmd_d = 1'b1;
            state_d = S_CLR;
          end
          ActPal: begin
            pal_we = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RUN: begin
        if (act_q == ActGlyph) begin
          if (gvalid) begin
            we = 1'b1;
            waddr = base_q + AW'(bx[ColW-1:0]);
            wdata = {sel[0] ? fg_q : bg_q, sel[1] ? fg_q : bg_q};
          end
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_d = S_DONE;
          end
        end else begin
          waddr = base_q + AW'(bc_q);
          last_d = (bc_q == endc_q);
          bc_d = bc_q + 10'd1;
          if (hi_c && lo_c) begin
            we = 1'b1;
            wdata = {fg_q, fg_q};
            if (bc_q == endc_q) begin
              state_d = S_DONE;
            end
          end else begin
            re = 1'b1;
            raddr = waddr;
            addr_d = waddr;
            mask_d = {hi_c, lo_c};
            state_d = S_RMW;
          end
        end
      end
      S_RMW: begin
        we = 1'b1;
        wdata = {mask_q[1] ? fg_q : rdata[7:4], mask_q[0] ? fg_q : rdata[3:0]};
        state_d = last_q ? S_DONE : S_RUN;
      end
      S_RDW: begin
        res_idx_d = rd_nib;
        res_rgb_d = pal_rd;
        res_in_d = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d = 1'b1;
          out_idx_d = res_idx_q;
          out_rgb_d = res_rgb_q;
          out_in_d = res_in_q;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        we = 1'b1;
        wdata = clr_cmd_q ? {fg_q, fg_q} : 8'd0;
        addr_d = addr_q + AW'(1);
        if (addr_q == LastAddr) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ovld_q <= 1'b0;
      clr_cmd_q <= 1'b0;
      addr_q <= '0;
    end else begin
      state_q <= state_d;
      ovld_q <= ovld_d;
      clr_cmd_q <= clr_cmd_d;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      len_q <= run_length_i;
      fg_q <= fore_color_i;
      bg_q <= back_color_i;
      bits_q <= glyph_bits_i;
      pidx_q <= palette_index_i;
      rgb_q <= rgb_value_i;
    end
    base_q <= base_d;
    s_q <= s_d;
    e_q <= e_d;
    bc_q <= bc_d;
    endc_q <= endc_d;
    k_q <= k_d;
    mask_q <= mask_d;
    last_q <= last_d;
    res_idx_q <= res_idx_d;
    res_rgb_q <= res_rgb_d;
    res_in_q <= res_in_d;
    out_idx_q <= out_idx_d;
    out_rgb_q <= out_rgb_d;
    out_in_q <= out_in_d;
  end

  assign out_valid_o = ovld_q;
  assign pixel_index_o = out_idx_q;
  assign pixel_rgb565_o = out_rgb_q;
  assign in_range_o = out_in_q;

endmodule
